>>> rtl/core/buzzer_pattern_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer assertion macros
// Concurrent check helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BUZZER_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define BUZZER_PATTERN_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define BPS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buzzer sequencer check failed");

// Next-cycle implication
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buzzer sequencer check failed");

`else

`define BPS_ASSERT_IMPLIES(lbl, ante, cons)
`define BPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Shared types, codes, widths and the millisecond-to-tick conversion.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Field widths
  localparam int MS_W    = 16;
  localparam int TICKS_W = 16;
  localparam int PAT_W   = 13;
  localparam int CNT_W   = 8;
  localparam int CMD_W   = 4;
  localparam int MODE_W  = 3;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  // Tick period and reciprocal for ceil(ms / TICK_MS)
  localparam int TICK_MS   = 10;
  localparam int TICK_W    = $clog2(TICK_MS);
  localparam int SUM_W     = MS_W + 1;
  localparam int DIV_SHIFT = SUM_W + TICK_W;
  localparam int RECIP     = ((2 ** DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam int PROD_W    = DIV_SHIFT + TICKS_W;

  localparam logic [PAT_W-1:0] PAT_MAX = '1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 4'd0,
    CMD_SHORT    = 4'd1,
    CMD_DOUBLE   = 4'd2,
    CMD_LONG     = 4'd3,
    CMD_TONE_ON  = 4'd4,
    CMD_TONE_OFF = 4'd5,
    CMD_TOGGLE   = 4'd6,
    CMD_STOP     = 4'd7,
    CMD_TIMED    = 4'd8,
    CMD_PULSES   = 4'd9,
    CMD_INIT     = 4'd10
  } bps_cmd_t;

  // Sound modes
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 3'd0,
    MODE_SHORT  = 3'd1,
    MODE_DOUBLE = 3'd2,
    MODE_LONG   = 3'd3,
    MODE_CONT   = 3'd4,
    MODE_PAT    = 3'd5
  } bps_mode_t;

  // Double beep phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_GAP    = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SHORT_TICKS = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_TICKS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAP_TICKS   = 2'd2;
  localparam logic [IDX_W-1:0] REG_SOUND_EN    = 2'd3;

  // Input transaction payload
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [MS_W-1:0]  timed_ms;
    logic [MS_W-1:0]  on_ms;
    logic [MS_W-1:0]  off_ms;
    logic [CNT_W-1:0] pulse_count;
    logic [MS_W-1:0]  repeat_ms;
  } bps_in_t;

  // Output transaction payload
  typedef struct packed {
    logic              sound_on;
    logic [MODE_W-1:0] mode;
  } bps_out_t;

  // Command held in the input register, times already in ticks
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TICKS_W-1:0] dur_ticks;
    logic [PAT_W-1:0]   high_ticks;
    logic [PAT_W-1:0]   low_ticks;
    logic [PAT_W-1:0]   rep_ticks;
    logic [CNT_W-1:0]   pulse_count;
  } bps_item_t;

  // ceil(ms / TICK_MS), at least one tick
  function automatic logic [TICKS_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod;
    logic [TICKS_W-1:0] q;
    sum  = SUM_W'(ms) + SUM_W'(TICK_MS - 1);
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    q    = prod[DIV_SHIFT +: TICKS_W];
    if (q == '0) begin
      q = TICKS_W'(1);
    end
    return q;
  endfunction

  // Clamp a tick count to the pattern counter range
  function automatic logic [PAT_W-1:0] sat_ticks(input logic [TICKS_W-1:0] t);
    logic [PAT_W-1:0] r;
    if (t > TICKS_W'(PAT_MAX)) begin
      r = PAT_MAX;
    end else begin
      r = t[PAT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/buzzer_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer core
// Command-driven buzzer sequencer: one result transaction per command.
// ----------------------------------------------------------------------------
// Each command transaction (a 10 ms tick or a sound command) yields exactly one
// result with the buzzer level and the sound mode after that command. Millisecond
// times become tick counts through a constant reciprocal multiply as a command
// enters the input register; once the result register has room, the engine
// applies it in a single state update and the result register captures the
// outcome. A command is taken every cycle while the sink keeps up; a result
// left waiting holds the input register, and the input stalls only while both
// registers are full.
// Configuration writes take effect at once and belong between transactions.
`include "buzzer_pattern_sequencer_core_defines.svh"

module buzzer_pattern_sequencer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bps_pkg::bps_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bps_pkg::bps_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [bps_pkg::IDX_W-1:0] cfg_index,
  input  logic [bps_pkg::CFG_W-1:0] cfg_data
);

  logic               stage_valid;
  bps_pkg::bps_item_t stage_item;
  bps_pkg::bps_out_t  result;
  logic               space;
  logic               advance;
  logic               result_idle;

  // Move a command through when the result register has room
  assign advance = stage_valid && space;

  bps_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  bps_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (stage_item),
    .result    (result)
  );

  bps_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks
  assign result_idle = (out_data.mode == 3'(bps_pkg::MODE_IDLE));

  `BPS_ASSERT_IMPLIES(a_idle_silent, out_valid && result_idle, !out_data.sound_on)
  `BPS_ASSERT_IMPLIES(a_stall_cause, !in_ready, stage_valid && out_valid && !out_ready)
  `BPS_ASSERT_NEXT(a_accept_held, in_valid && in_ready, stage_valid)

endmodule

>>> rtl/core/bps_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer sequencer input stage
// Registers one command transaction and converts its times to ticks.
// ----------------------------------------------------------------------------
module bps_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bps_pkg::bps_in_t  in_data,
  input  logic              take,
  output logic              stage_valid,
  output bps_pkg::bps_item_t stage_item
);

  bps_pkg::bps_item_t conv;

  // Accept when empty or when the held command moves on this cycle
  assign in_ready = !stage_valid || take;

  // Convert millisecond fields to tick counts
  always_comb begin
    conv.command     = in_data.command;
    conv.dur_ticks   = bps_pkg::ms_to_ticks(in_data.timed_ms);
    conv.high_ticks  = bps_pkg::sat_ticks(bps_pkg::ms_to_ticks(in_data.on_ms));
    conv.low_ticks   = bps_pkg::sat_ticks(bps_pkg::ms_to_ticks(in_data.off_ms));
    if (in_data.repeat_ms == '0) begin
      conv.rep_ticks = '0;
    end else begin
      conv.rep_ticks = bps_pkg::sat_ticks(bps_pkg::ms_to_ticks(in_data.repeat_ms));
    end
    conv.pulse_count = in_data.pulse_count;
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= conv;
    end
  end

endmodule

>>> rtl/core/bps_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer sequencer engine
// Configuration registers, sound state and the per-command state update.
// ----------------------------------------------------------------------------
module bps_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bps_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          step,
  input  bps_pkg::bps_item_t            item,
  output bps_pkg::bps_out_t             result
);

  // Configuration
  logic [bps_pkg::TICKS_W-1:0] short_beep_ticks;
  logic [bps_pkg::TICKS_W-1:0] long_beep_ticks;
  logic [bps_pkg::TICKS_W-1:0] gap_ticks;
  logic                        sound_enable;

  // Sound state
  bps_pkg::bps_mode_t          mode_reg, mode_reg_next;
  logic [bps_pkg::TICKS_W-1:0] beep_count, beep_count_next;
  logic [1:0]                  double_phase, double_phase_next;
  logic                        tone_phase, tone_phase_next;
  logic [bps_pkg::PAT_W-1:0]   pat_high_ticks, pat_high_ticks_next;
  logic [bps_pkg::PAT_W-1:0]   pat_low_ticks, pat_low_ticks_next;
  logic [bps_pkg::PAT_W-1:0]   pat_repeat_ticks, pat_repeat_ticks_next;
  logic [bps_pkg::PAT_W-1:0]   pat_count, pat_count_next;
  logic [bps_pkg::PAT_W-1:0]   repeat_count, repeat_count_next;
  logic [bps_pkg::CNT_W-1:0]   burst_total, burst_total_next;
  logic [bps_pkg::CNT_W-1:0]   pulses_left, pulses_left_next;
  logic                        resume_valid, resume_valid_next;
  logic                        resume_is_pattern, resume_is_pattern_next;
  logic [bps_pkg::PAT_W-1:0]   resume_on, resume_on_next;
  logic [bps_pkg::PAT_W-1:0]   resume_off, resume_off_next;
  logic [bps_pkg::PAT_W-1:0]   resume_repeat, resume_repeat_next;
  logic [bps_pkg::CNT_W-1:0]   resume_pulses, resume_pulses_next;

  logic do_end;
  logic do_load;
  logic in_beep;
  logic level;

  assign in_beep = (mode_reg == bps_pkg::MODE_SHORT) || (mode_reg == bps_pkg::MODE_DOUBLE)
                || (mode_reg == bps_pkg::MODE_LONG);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_beep_ticks <= bps_pkg::TICKS_W'(1);
      long_beep_ticks  <= bps_pkg::TICKS_W'(10);
      gap_ticks        <= bps_pkg::TICKS_W'(10);
      sound_enable     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bps_pkg::REG_SHORT_TICKS: short_beep_ticks <= cfg_data;
        bps_pkg::REG_LONG_TICKS:  long_beep_ticks  <= cfg_data;
        bps_pkg::REG_GAP_TICKS:   gap_ticks        <= cfg_data;
        bps_pkg::REG_SOUND_EN:    sound_enable     <= cfg_data[0];
      endcase
    end
  end

  // Next state for one command
  always_comb begin
    mode_reg_next          = mode_reg;
    beep_count_next        = beep_count;
    double_phase_next      = double_phase;
    tone_phase_next        = tone_phase;
    pat_high_ticks_next    = pat_high_ticks;
    pat_low_ticks_next     = pat_low_ticks;
    pat_repeat_ticks_next  = pat_repeat_ticks;
    pat_count_next         = pat_count;
    repeat_count_next      = repeat_count;
    burst_total_next       = burst_total;
    pulses_left_next       = pulses_left;
    resume_valid_next      = resume_valid;
    resume_is_pattern_next = resume_is_pattern;
    resume_on_next         = resume_on;
    resume_off_next        = resume_off;
    resume_repeat_next     = resume_repeat;
    resume_pulses_next     = resume_pulses;
    do_end                 = 1'b0;
    do_load                = 1'b0;

    unique case (item.command)
      bps_pkg::CMD_TICK: begin
        unique case (mode_reg)
          bps_pkg::MODE_IDLE, bps_pkg::MODE_CONT: begin
          end
          bps_pkg::MODE_SHORT, bps_pkg::MODE_LONG: begin
            if (beep_count != '0) begin
              beep_count_next = beep_count - bps_pkg::TICKS_W'(1);
            end else begin
              do_end = 1'b1;
            end
          end
          bps_pkg::MODE_DOUBLE: begin
            if (beep_count != '0) begin
              beep_count_next = beep_count - bps_pkg::TICKS_W'(1);
            end else if (double_phase == bps_pkg::PH_FIRST) begin
              double_phase_next = bps_pkg::PH_GAP;
              beep_count_next   = gap_ticks;
            end else if (double_phase == bps_pkg::PH_GAP) begin
              double_phase_next = bps_pkg::PH_SECOND;
              beep_count_next   = short_beep_ticks;
            end else begin
              // second beep done, or an out-of-range phase
              double_phase_next = bps_pkg::PH_FIRST;
              do_end            = 1'b1;
            end
          end
          bps_pkg::MODE_PAT: begin
            if (pat_count != '0) begin
              pat_count_next = pat_count - bps_pkg::PAT_W'(1);
            end else if (tone_phase) begin
              tone_phase_next = 1'b0;
              pat_count_next  = pat_low_ticks;
              if (pulses_left != '0) begin
                pulses_left_next = pulses_left - bps_pkg::CNT_W'(1);
              end
            end else if (pulses_left != '0) begin
              tone_phase_next = 1'b1;
              pat_count_next  = pat_high_ticks;
            end else if (pat_repeat_ticks == '0) begin
              mode_reg_next = bps_pkg::MODE_IDLE;
            end else if (repeat_count < pat_repeat_ticks) begin
              repeat_count_next = repeat_count + bps_pkg::PAT_W'(1);
              pat_count_next    = bps_pkg::PAT_W'(1);
            end else begin
              do_load = 1'b1;
            end
          end
          default: begin
            mode_reg_next = bps_pkg::MODE_IDLE;
          end
        endcase
      end
      bps_pkg::CMD_SHORT, bps_pkg::CMD_DOUBLE, bps_pkg::CMD_LONG: begin
        // save a running tone or repeating pattern
        if (!in_beep) begin
          resume_valid_next = 1'b0;
          if (mode_reg == bps_pkg::MODE_CONT) begin
            resume_valid_next      = 1'b1;
            resume_is_pattern_next = 1'b0;
          end else if (mode_reg == bps_pkg::MODE_PAT && pat_repeat_ticks != '0) begin
            resume_valid_next      = 1'b1;
            resume_is_pattern_next = 1'b1;
            resume_on_next         = pat_high_ticks;
            resume_off_next        = pat_low_ticks;
            resume_repeat_next     = pat_repeat_ticks;
            resume_pulses_next     = burst_total;
          end
        end
        if (item.command == bps_pkg::CMD_LONG) begin
          mode_reg_next   = bps_pkg::MODE_LONG;
          beep_count_next = long_beep_ticks;
        end else if (item.command == bps_pkg::CMD_DOUBLE) begin
          mode_reg_next   = bps_pkg::MODE_DOUBLE;
          beep_count_next = short_beep_ticks;
        end else begin
          mode_reg_next   = bps_pkg::MODE_SHORT;
          beep_count_next = short_beep_ticks;
        end
        double_phase_next = bps_pkg::PH_FIRST;
      end
      bps_pkg::CMD_TONE_ON: begin
        resume_valid_next = 1'b0;
        mode_reg_next     = bps_pkg::MODE_CONT;
        beep_count_next   = '0;
        double_phase_next = bps_pkg::PH_FIRST;
      end
      bps_pkg::CMD_TONE_OFF: begin
        if (mode_reg == bps_pkg::MODE_CONT) begin
          mode_reg_next     = bps_pkg::MODE_IDLE;
          resume_valid_next = 1'b0;
        end
      end
      bps_pkg::CMD_TOGGLE: begin
        if (mode_reg == bps_pkg::MODE_CONT) begin
          mode_reg_next     = bps_pkg::MODE_IDLE;
          resume_valid_next = 1'b0;
        end else begin
          resume_valid_next = 1'b0;
          mode_reg_next     = bps_pkg::MODE_CONT;
          beep_count_next   = '0;
          double_phase_next = bps_pkg::PH_FIRST;
        end
      end
      bps_pkg::CMD_STOP: begin
        if (mode_reg == bps_pkg::MODE_PAT) begin
          mode_reg_next     = bps_pkg::MODE_IDLE;
          resume_valid_next = 1'b0;
        end
      end
      bps_pkg::CMD_TIMED: begin
        // timed one-shot leaves any saved context alone
        mode_reg_next     = bps_pkg::MODE_LONG;
        beep_count_next   = item.dur_ticks;
        double_phase_next = bps_pkg::PH_FIRST;
      end
      bps_pkg::CMD_PULSES: begin
        if (item.pulse_count == '0) begin
          if (mode_reg == bps_pkg::MODE_PAT) begin
            mode_reg_next     = bps_pkg::MODE_IDLE;
            resume_valid_next = 1'b0;
          end
        end else begin
          resume_valid_next     = 1'b0;
          pat_high_ticks_next   = item.high_ticks;
          pat_low_ticks_next    = item.low_ticks;
          pat_repeat_ticks_next = item.rep_ticks;
          burst_total_next      = item.pulse_count;
          do_load               = 1'b1;
        end
      end
      bps_pkg::CMD_INIT: begin
        mode_reg_next     = bps_pkg::MODE_IDLE;
        beep_count_next   = '0;
        double_phase_next = bps_pkg::PH_FIRST;
      end
      default: begin
      end
    endcase

    // End of a one-shot: resume saved sound or drop to idle
    if (do_end) begin
      if (!resume_valid) begin
        mode_reg_next = bps_pkg::MODE_IDLE;
      end else begin
        resume_valid_next = 1'b0;
        if (!resume_is_pattern) begin
          mode_reg_next     = bps_pkg::MODE_CONT;
          beep_count_next   = '0;
          double_phase_next = bps_pkg::PH_FIRST;
        end else if (resume_pulses != '0) begin
          pat_high_ticks_next   = resume_on;
          pat_low_ticks_next    = resume_off;
          pat_repeat_ticks_next = resume_repeat;
          burst_total_next      = resume_pulses;
          do_load               = 1'b1;
        end else begin
          mode_reg_next = bps_pkg::MODE_IDLE;
        end
      end
    end

    // Restart the pulse train from its first pulse
    if (do_load) begin
      pulses_left_next  = burst_total_next;
      tone_phase_next   = 1'b1;
      pat_count_next    = pat_high_ticks_next;
      repeat_count_next = '0;
      mode_reg_next     = bps_pkg::MODE_PAT;
    end
  end

  // Drive level after the step
  always_comb begin
    unique case (mode_reg_next)
      bps_pkg::MODE_SHORT, bps_pkg::MODE_LONG, bps_pkg::MODE_CONT: level = 1'b1;
      bps_pkg::MODE_DOUBLE: level = (double_phase_next != bps_pkg::PH_GAP);
      bps_pkg::MODE_PAT:    level = tone_phase_next;
      default:              level = 1'b0;
    endcase
  end

  assign result.sound_on = level & sound_enable;
  assign result.mode     = mode_reg_next;

  // Advance state on each command
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= bps_pkg::MODE_IDLE;
      beep_count        <= '0;
      double_phase      <= '0;
      tone_phase        <= 1'b0;
      pat_high_ticks    <= '0;
      pat_low_ticks     <= '0;
      pat_repeat_ticks  <= '0;
      pat_count         <= '0;
      repeat_count      <= '0;
      burst_total       <= '0;
      pulses_left       <= '0;
      resume_valid      <= 1'b0;
      resume_is_pattern <= 1'b0;
      resume_on         <= '0;
      resume_off        <= '0;
      resume_repeat     <= '0;
      resume_pulses     <= '0;
    end else if (step) begin
      mode_reg          <= mode_reg_next;
      beep_count        <= beep_count_next;
      double_phase      <= double_phase_next;
      tone_phase        <= tone_phase_next;
      pat_high_ticks    <= pat_high_ticks_next;
      pat_low_ticks     <= pat_low_ticks_next;
      pat_repeat_ticks  <= pat_repeat_ticks_next;
      pat_count         <= pat_count_next;
      repeat_count      <= repeat_count_next;
      burst_total       <= burst_total_next;
      pulses_left       <= pulses_left_next;
      resume_valid      <= resume_valid_next;
      resume_is_pattern <= resume_is_pattern_next;
      resume_on         <= resume_on_next;
      resume_off        <= resume_off_next;
      resume_repeat     <= resume_repeat_next;
      resume_pulses     <= resume_pulses_next;
    end
  end

endmodule

>>> rtl/core/bps_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer sequencer output stage
// Result register that holds a transaction until the sink takes it.
// ----------------------------------------------------------------------------
module bps_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bps_pkg::bps_out_t result,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output bps_pkg::bps_out_t out_data
);

  // Room when empty or when the held result leaves this cycle
  assign space = !out_valid || out_ready;

  // Track the held result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture a new result
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer testbench
// Drives command transactions through bursty valid/ready traffic, predicts
// the buzzer level and sound mode of every command with a local model of the
// sequencer, and checks each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int          RUN_LIMIT     = 300000;
  localparam int          ITEMS_PER_SET = 440;
  localparam logic [3:0]  CMD_UNUSED_LO = 4'd11;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  bps_pkg::bps_in_t           in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bps_pkg::bps_out_t          out_data;
  logic                       cfg_we = 1'b0;
  logic [bps_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [bps_pkg::CFG_W-1:0]  cfg_data = '0;

  bps_pkg::bps_in_t           command_queue[$];
  bps_pkg::bps_out_t          predicted_levels[$];
  int                         error_count = 0;
  int                         cycle_count = 0;
  int                         gap_left = 0;
  int                         burst_left = 0;

  // Local copy of the sequencer configuration
  logic [15:0]                cfg_short;
  logic [15:0]                cfg_long;
  logic [15:0]                cfg_gap;
  logic                       cfg_sound_en;

  // Local copy of the sequencer state
  bps_pkg::bps_mode_t         cur_mode;
  logic [15:0]                beep_left;
  logic [1:0]                 dbl_phase;
  logic                       pulse_high;
  logic [bps_pkg::PAT_W-1:0]  on_len, off_len, rep_len, phase_left, rep_wait;
  logic [bps_pkg::CNT_W-1:0]  burst_pulses, pulses_remaining;
  logic                       saved_valid, saved_is_train;
  logic [bps_pkg::PAT_W-1:0]  saved_on, saved_off, saved_rep;
  logic [bps_pkg::CNT_W-1:0]  saved_pulses;

  buzzer_pattern_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ceil(ms / tick period), never below one tick
  function automatic logic [15:0] ms_ceil_ticks(input logic [15:0] ms);
    int t;
    t = (int'(ms) + bps_pkg::TICK_MS - 1) / bps_pkg::TICK_MS;
    if (t == 0) begin
      t = 1;
    end
    return t[15:0];
  endfunction

  // Same conversion, clamped to the pattern counter width
  function automatic logic [bps_pkg::PAT_W-1:0] pattern_ticks(input logic [15:0] ms);
    logic [15:0] t;
    t = ms_ceil_ticks(ms);
    return (t > 16'(bps_pkg::PAT_MAX)) ? bps_pkg::PAT_MAX : t[bps_pkg::PAT_W-1:0];
  endfunction

  function automatic void restart_pattern();
    pulses_remaining = burst_pulses;
    pulse_high = 1'b1;
    phase_left = on_len;
    rep_wait = '0;
    cur_mode = bps_pkg::MODE_PAT;
  endfunction

  // Resume a saved tone or repeating train once a one-shot ends
  function automatic void finish_beep();
    if (!saved_valid) begin
      cur_mode = bps_pkg::MODE_IDLE;
    end else begin
      saved_valid = 1'b0;
      if (!saved_is_train) begin
        cur_mode = bps_pkg::MODE_CONT;
        beep_left = '0;
        dbl_phase = bps_pkg::PH_FIRST;
      end else if (saved_pulses != 0) begin
        on_len = saved_on;
        off_len = saved_off;
        rep_len = saved_rep;
        burst_pulses = saved_pulses;
        restart_pattern();
      end else begin
        cur_mode = bps_pkg::MODE_IDLE;
      end
    end
  endfunction

  // Start a short, double or long beep, saving a running sound first
  function automatic void begin_beep(input bps_pkg::bps_mode_t m, input logic [15:0] load);
    if (cur_mode != bps_pkg::MODE_SHORT && cur_mode != bps_pkg::MODE_DOUBLE &&
        cur_mode != bps_pkg::MODE_LONG) begin
      saved_valid = 1'b0;
      if (cur_mode == bps_pkg::MODE_CONT) begin
        saved_valid = 1'b1;
        saved_is_train = 1'b0;
      end else if (cur_mode == bps_pkg::MODE_PAT && rep_len != 0) begin
        saved_valid = 1'b1;
        saved_is_train = 1'b1;
        saved_on = on_len;
        saved_off = off_len;
        saved_rep = rep_len;
        saved_pulses = burst_pulses;
      end
    end
    cur_mode = m;
    beep_left = load;
    dbl_phase = bps_pkg::PH_FIRST;
  endfunction

  function automatic void start_tone();
    saved_valid = 1'b0;
    cur_mode = bps_pkg::MODE_CONT;
    beep_left = '0;
    dbl_phase = bps_pkg::PH_FIRST;
  endfunction

  function automatic void halt_pattern();
    if (cur_mode == bps_pkg::MODE_PAT) begin
      cur_mode = bps_pkg::MODE_IDLE;
      saved_valid = 1'b0;
    end
  endfunction

  function automatic void reset_sequencer();
    cfg_short = 16'd1;
    cfg_long = 16'd10;
    cfg_gap = 16'd10;
    cfg_sound_en = 1'b1;
    cur_mode = bps_pkg::MODE_IDLE;
    beep_left = '0;
    dbl_phase = bps_pkg::PH_FIRST;
    pulse_high = 1'b0;
    {on_len, off_len, rep_len, phase_left, rep_wait} = '0;
    {burst_pulses, pulses_remaining} = '0;
    {saved_valid, saved_is_train, saved_on, saved_off, saved_rep, saved_pulses} = '0;
  endfunction

  // Apply one command and return the level and mode that follow it
  function automatic bps_pkg::bps_out_t sequencer_step(input bps_pkg::bps_in_t it);
    bps_pkg::bps_out_t res;
    logic              level;
    case (it.command)
      bps_pkg::CMD_TICK: begin
        case (cur_mode)
          bps_pkg::MODE_IDLE, bps_pkg::MODE_CONT: begin
          end
          bps_pkg::MODE_SHORT, bps_pkg::MODE_LONG: begin
            if (beep_left != 0) beep_left--;
            else finish_beep();
          end
          bps_pkg::MODE_DOUBLE: begin
            if (beep_left != 0) begin
              beep_left--;
            end else if (dbl_phase == bps_pkg::PH_FIRST) begin
              dbl_phase = bps_pkg::PH_GAP;
              beep_left = cfg_gap;
            end else if (dbl_phase == bps_pkg::PH_GAP) begin
              dbl_phase = bps_pkg::PH_SECOND;
              beep_left = cfg_short;
            end else begin
              dbl_phase = bps_pkg::PH_FIRST;
              finish_beep();
            end
          end
          bps_pkg::MODE_PAT: begin
            if (phase_left != 0) begin
              phase_left--;
            end else if (pulse_high) begin
              pulse_high = 1'b0;
              phase_left = off_len;
              if (pulses_remaining != 0) pulses_remaining--;
            end else if (pulses_remaining != 0) begin
              pulse_high = 1'b1;
              phase_left = on_len;
            end else if (rep_len == 0) begin
              cur_mode = bps_pkg::MODE_IDLE;
            end else if (rep_wait < rep_len) begin
              rep_wait++;
              phase_left = bps_pkg::PAT_W'(1);
            end else begin
              restart_pattern();
            end
          end
          default: cur_mode = bps_pkg::MODE_IDLE;
        endcase
      end
      bps_pkg::CMD_SHORT:   begin_beep(bps_pkg::MODE_SHORT, cfg_short);
      bps_pkg::CMD_DOUBLE:  begin_beep(bps_pkg::MODE_DOUBLE, cfg_short);
      bps_pkg::CMD_LONG:    begin_beep(bps_pkg::MODE_LONG, cfg_long);
      bps_pkg::CMD_TONE_ON: start_tone();
      bps_pkg::CMD_TONE_OFF: begin
        if (cur_mode == bps_pkg::MODE_CONT) begin
          cur_mode = bps_pkg::MODE_IDLE;
          saved_valid = 1'b0;
        end
      end
      bps_pkg::CMD_TOGGLE: begin
        if (cur_mode == bps_pkg::MODE_CONT) begin
          cur_mode = bps_pkg::MODE_IDLE;
          saved_valid = 1'b0;
        end else begin
          start_tone();
        end
      end
      bps_pkg::CMD_STOP: halt_pattern();
      bps_pkg::CMD_TIMED: begin
        cur_mode = bps_pkg::MODE_LONG;
        beep_left = ms_ceil_ticks(it.timed_ms);
        dbl_phase = bps_pkg::PH_FIRST;
      end
      bps_pkg::CMD_PULSES: begin
        if (it.pulse_count == 0) begin
          halt_pattern();
        end else begin
          saved_valid = 1'b0;
          on_len = pattern_ticks(it.on_ms);
          off_len = pattern_ticks(it.off_ms);
          rep_len = (it.repeat_ms == 0) ? '0 : pattern_ticks(it.repeat_ms);
          burst_pulses = it.pulse_count;
          restart_pattern();
        end
      end
      bps_pkg::CMD_INIT: begin
        cur_mode = bps_pkg::MODE_IDLE;
        beep_left = '0;
        dbl_phase = bps_pkg::PH_FIRST;
      end
      default: begin
      end
    endcase

    case (cur_mode)
      bps_pkg::MODE_SHORT, bps_pkg::MODE_LONG, bps_pkg::MODE_CONT: level = 1'b1;
      bps_pkg::MODE_DOUBLE: level = (dbl_phase != bps_pkg::PH_GAP);
      bps_pkg::MODE_PAT:    level = pulse_high;
      default:              level = 1'b0;
    endcase
    res.sound_on = level & cfg_sound_en;
    res.mode = cur_mode;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Write all four registers, one per cycle, while the block is idle
  task automatic write_config(input logic [15:0] s, input logic [15:0] l,
                              input logic [15:0] g, input logic en);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bps_pkg::REG_SHORT_TICKS;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= bps_pkg::REG_LONG_TICKS;
    cfg_data <= l;
    @(posedge clk);
    cfg_index <= bps_pkg::REG_GAP_TICKS;
    cfg_data <= g;
    @(posedge clk);
    cfg_index <= bps_pkg::REG_SOUND_EN;
    cfg_data <= bps_pkg::CFG_W'(en);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_short = s;
    cfg_long = l;
    cfg_gap = g;
    cfg_sound_en = en;
  endtask

  function automatic bps_pkg::bps_in_t make_cmd(input bps_pkg::bps_cmd_t c,
                                                input logic [15:0] dur,
                                                input logic [15:0] on, input logic [15:0] off,
                                                input logic [7:0] cnt, input logic [15:0] rep);
    bps_pkg::bps_in_t it;
    it.command = c;
    it.timed_ms = dur;
    it.on_ms = on;
    it.off_ms = off;
    it.pulse_count = cnt;
    it.repeat_ms = rep;
    return it;
  endfunction

  // Command with every time and count field at zero
  function automatic bps_pkg::bps_in_t plain_cmd(input bps_pkg::bps_cmd_t c);
    return make_cmd(c, '0, '0, '0, '0, '0);
  endfunction

  function automatic bps_pkg::bps_in_t noise_cmd(input logic [3:0] c);
    bps_pkg::bps_in_t it;
    it.command = c;
    it.timed_ms = 16'($urandom);
    it.on_ms = 16'($urandom);
    it.off_ms = 16'($urandom);
    it.pulse_count = 8'($urandom);
    it.repeat_ms = 16'($urandom);
    return it;
  endfunction

  // Mostly a sound command followed by a run of ticks that plays it out
  task automatic add_random(input int n_items);
    int               added;
    int               pick;
    int               run;
    bps_pkg::bps_in_t it;
    added = 0;
    while (added < n_items) begin
      it = noise_cmd(bps_pkg::CMD_TICK);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        it.command = bps_pkg::CMD_PULSES;
        if ($urandom_range(0, 15) != 0) begin
          it.on_ms = 16'($urandom_range(0, 40));
          it.off_ms = 16'($urandom_range(0, 40));
          it.pulse_count = 8'($urandom_range(1, 4));
          it.repeat_ms = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom_range(1, 50));
        end else if (it.pulse_count == 0) begin
          it.pulse_count = 8'd1;
        end
      end else if (pick < 45) begin
        it.command = 4'($urandom_range(bps_pkg::CMD_SHORT, bps_pkg::CMD_LONG));
      end else if (pick < 55) begin
        it.command = 4'($urandom_range(bps_pkg::CMD_TONE_ON, bps_pkg::CMD_TOGGLE));
      end else if (pick < 62) begin
        it.command = bps_pkg::CMD_TIMED;
        if ($urandom_range(0, 7) != 0) it.timed_ms = 16'($urandom_range(0, 50));
      end else if (pick < 66) begin
        case ($urandom_range(0, 2))
          0: it.command = bps_pkg::CMD_STOP;
          1: it.command = bps_pkg::CMD_INIT;
          default: it.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        endcase
      end else if (pick < 70) begin
        it.command = bps_pkg::CMD_PULSES;
        it.pulse_count = '0;
      end
      if (pick < 70) begin
        command_queue.push_back(it);
        added++;
      end
      run = $urandom_range(0, 14);
      repeat (run) begin
        command_queue.push_back(noise_cmd(bps_pkg::CMD_TICK));
        added++;
      end
    end
  endtask

  // Hold until every queued command has produced its result, then let it settle
  task automatic drain();
    while (command_queue.size() != 0 || in_valid || predicted_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Driver: bursts of commands separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
      reset_sequencer();
    end else begin
      if (in_valid && in_ready) begin
        predicted_levels.push_back(sequencer_step(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (command_queue.size() != 0) begin
          in_data <= command_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall on a cycling pattern and check each result transaction
  always @(posedge clk) begin
    bps_pkg::bps_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_levels.size() == 0) begin
          report_mismatch("result with no command pending");
        end else begin
          want = predicted_levels.pop_front();
          if (out_data.sound_on !== want.sound_on) begin
            report_mismatch($sformatf("sound_on %b, expected %b",
                                      out_data.sound_on, want.sound_on));
          end
          if (out_data.mode !== want.mode) begin
            report_mismatch($sformatf("mode %0d, expected %0d", out_data.mode, want.mode));
          end
        end
      end
      case (cycle_count[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= (cycle_count[1:0] != 2'd0);
        2'd2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (cycle_count[2:0] == 3'd0);
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every command, context save and resume, stale resume
    write_config(16'd0, 16'd1, 16'd0, 1'b1);
    command_queue.push_back(make_cmd(bps_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     8'hFF, 16'hFFFF));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TONE_ON));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_SHORT));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TICK));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TOGGLE));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TOGGLE));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TONE_OFF));
    command_queue.push_back(make_cmd(bps_pkg::CMD_PULSES, '0, '0, 16'hFFFF, 8'd1, 16'hFFFF));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_DOUBLE));
    repeat (3) command_queue.push_back(plain_cmd(bps_pkg::CMD_TICK));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_TONE_ON));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_LONG));
    command_queue.push_back(make_cmd(bps_pkg::CMD_TIMED, 16'd1, '0, '0, '0, '0));
    repeat (2) command_queue.push_back(plain_cmd(bps_pkg::CMD_TICK));
    command_queue.push_back(make_cmd(bps_pkg::CMD_PULSES, '0, 16'hFFFF, '0, 8'hFF, '0));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_STOP));
    command_queue.push_back(make_cmd(bps_pkg::CMD_PULSES, '0, 16'd25, 16'd5, 8'd2, '0));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_PULSES));
    command_queue.push_back(plain_cmd(bps_pkg::bps_cmd_t'(CMD_UNUSED_HI)));
    command_queue.push_back(plain_cmd(bps_pkg::CMD_INIT));
    command_queue.push_back(make_cmd(bps_pkg::CMD_TIMED, 16'hFFFF, '0, '0, '0, '0));
    drain();

    // Random traffic under several register settings, extremes included
    write_config(16'd1, 16'd10, 16'd10, 1'b1);
    add_random(ITEMS_PER_SET);
    drain();
    write_config(16'd0, 16'd0, 16'd0, 1'b0);
    add_random(ITEMS_PER_SET);
    drain();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_random(ITEMS_PER_SET);
    drain();
    write_config(16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                 16'($urandom_range(0, 4)), 1'b1);
    add_random(ITEMS_PER_SET);
    drain();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
